// File: src/bgb_pkg.sv
// shared types and constants for the gravity bounce step unit
package bgb_pkg;

  localparam int MAX_BODIES_DEF = 8;

  localparam logic [11:0] GRAVITY_RESET = 12'd384;
  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int FLAG_GRAVITY = 0;
  localparam int FLAG_ELASTIC = 1;
  localparam int FLAG_FRICTION = 2;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] speed_x;
    logic signed [23:0] speed_y;
    logic signed [23:0] drift_y;
    logic signed [23:0] box_cx;
    logic signed [23:0] box_cy;
    logic [10:0] half_w;
    logic [10:0] half_h;
    logic [10:0] radius;
    logic [2:0] mode;
    logic [11:0] weight;
    logic [8:0] bounce;
    logic [8:0] drag;
  } body_t;

endpackage

// File: src/body_gravity_bounce_step_unit.sv
// top level of the gravity bounce step unit
//
//  channel   signals                                   direction
//  request   start, busy, operation .. drag_factor     in (busy out)
//  result    result_strobe, out_index .. last_body     out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// a load writes its slot of the body table and leaves busy low. a tick
// visits every slot; per valid body it runs gravity, a pair scan over the
// other valid bodies with a bounce per overlapping pair, wall, friction
// and drift, paced by the shared multiplier and the single read port of
// the body table. reset clears slot valids and restores config defaults.
// results cannot be stalled; each is shown for one cycle on result_strobe.
module body_gravity_bounce_step_unit #(
  parameter int MAX_BODIES = bgb_pkg::MAX_BODIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic operation,
  input  logic [2:0] body_index,
  input  logic signed [23:0] start_x,
  input  logic signed [23:0] start_y,
  input  logic signed [23:0] horiz_speed,
  input  logic signed [23:0] vert_drift,
  input  logic [11:0] box_width,
  input  logic [11:0] box_height,
  input  logic [2:0] mode_flags,
  input  logic [11:0] mass_weight,
  input  logic [8:0] bounce_factor,
  input  logic [8:0] drag_factor,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data,
  output logic result_strobe,
  output logic [2:0] out_index,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic on_ground,
  output logic last_body
);

  localparam int IW = $clog2(MAX_BODIES);

  logic [11:0] gravity_accel, arena_width, arena_height;
  logic mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  bgb_pkg::body_t mem_wdata, mem_rdata;
  logic signed [24:0] mul_a;
  logic signed [12:0] mul_b;
  logic signed [37:0] mul_p;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_accel <= bgb_pkg::GRAVITY_RESET;
      arena_width <= bgb_pkg::WIDTH_RESET;
      arena_height <= bgb_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgb_pkg::REG_GRAVITY: gravity_accel <= cfg_data;
        bgb_pkg::REG_WIDTH: arena_width <= cfg_data;
        bgb_pkg::REG_HEIGHT: arena_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bgb_mem #(.DEPTH(MAX_BODIES), .IW(IW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  bgb_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  bgb_seq #(.MAX_BODIES(MAX_BODIES), .IW(IW)) u_seq (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .body_index(body_index), .start_x(start_x), .start_y(start_y),
    .horiz_speed(horiz_speed), .vert_drift(vert_drift),
    .box_width(box_width), .box_height(box_height), .mode_flags(mode_flags),
    .mass_weight(mass_weight), .bounce_factor(bounce_factor),
    .drag_factor(drag_factor), .gravity_accel(gravity_accel),
    .arena_width(arena_width), .arena_height(arena_height),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata),
    .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p),
    .result_strobe(result_strobe), .out_index(out_index), .out_x(out_x),
    .out_y(out_y), .on_ground(on_ground), .last_body(last_body)
  );

endmodule

// File: src/bgb_mem.sv
// body table memory, one write port and one registered read port
module bgb_mem #(
  parameter int DEPTH = bgb_pkg::MAX_BODIES_DEF,
  parameter int IW = $clog2(DEPTH)
) (
  input  logic clk,
  input  logic we,
  input  logic [IW-1:0] waddr,
  input  bgb_pkg::body_t wdata,
  input  logic [IW-1:0] raddr,
  output bgb_pkg::body_t rdata
);

  bgb_pkg::body_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bgb_mul.sv
// shared registered multiplier
module bgb_mul (
  input  logic clk,
  input  logic signed [24:0] a,
  input  logic signed [12:0] b,
  output logic signed [37:0] p
);

  always_ff @(posedge clk) begin
    p <= 38'(a * b);
  end

endmodule

// File: src/bgb_seq.sv
// sequencer and datapath that walks the body table for one tick
module bgb_seq #(
  parameter int MAX_BODIES = bgb_pkg::MAX_BODIES_DEF,
  parameter int IW = $clog2(MAX_BODIES)
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic operation,
  input  logic [2:0] body_index,
  input  logic signed [23:0] start_x,
  input  logic signed [23:0] start_y,
  input  logic signed [23:0] horiz_speed,
  input  logic signed [23:0] vert_drift,
  input  logic [11:0] box_width,
  input  logic [11:0] box_height,
  input  logic [2:0] mode_flags,
  input  logic [11:0] mass_weight,
  input  logic [8:0] bounce_factor,
  input  logic [8:0] drag_factor,
  input  logic [11:0] gravity_accel,
  input  logic [11:0] arena_width,
  input  logic [11:0] arena_height,
  output logic mem_we,
  output logic [IW-1:0] mem_waddr,
  output bgb_pkg::body_t mem_wdata,
  output logic [IW-1:0] mem_raddr,
  input  bgb_pkg::body_t mem_rdata,
  output logic signed [24:0] mul_a,
  output logic signed [12:0] mul_b,
  input  logic signed [37:0] mul_p,
  output logic result_strobe,
  output logic [2:0] out_index,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic on_ground,
  output logic last_body
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SCAN = 5'd1;
  localparam logic [4:0] S_LOADB = 5'd2;
  localparam logic [4:0] S_GRAV = 5'd3;
  localparam logic [4:0] S_GRAV_M = 5'd4;
  localparam logic [4:0] S_GRAV_P = 5'd5;
  localparam logic [4:0] S_PAIR_ADDR = 5'd6;
  localparam logic [4:0] S_PAIR_CHK = 5'd7;
  localparam logic [4:0] S_PAIR_B = 5'd8;
  localparam logic [4:0] S_PAIR_O = 5'd9;
  localparam logic [4:0] S_PAIR_OM = 5'd10;
  localparam logic [4:0] S_PAIR_WR = 5'd11;
  localparam logic [4:0] S_WALL = 5'd12;
  localparam logic [4:0] S_WALL_M = 5'd13;
  localparam logic [4:0] S_FRIC = 5'd14;
  localparam logic [4:0] S_FRIC_M = 5'd15;
  localparam logic [4:0] S_MOVEX = 5'd16;
  localparam logic [4:0] S_DRIFT = 5'd17;
  localparam logic [4:0] S_EMIT = 5'd18;

  localparam logic [IW-1:0] LAST = IW'(MAX_BODIES - 1);

  logic [4:0] state;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [MAX_BODIES-1:0] slot_valid;
  bgb_pkg::body_t w;
  bgb_pkg::body_t ow;
  logic signed [23:0] o_sy;
  logic grounded;

  logic signed [27:0] py28, sy28, px28, sx28, r28, fl28, wl28, nx28;
  logic fall, hit, ovl, gnd_now, load_ok;
  logic signed [23:0] scaled;
  logic signed [26:0] al, ar, at, ab, bl, br, bt, bb;
  bgb_pkg::body_t load_word;
  logic [12:0] size_sum;

  assign busy = (state != S_IDLE);
  assign scaled = mul_p[31:8];
  assign load_ok = ({{(IW + 3){1'b0}}, body_index} < (IW + 6)'(MAX_BODIES));

  always_comb begin
    py28 = {{4{w.pos_y[23]}}, w.pos_y};
    sy28 = {{4{w.speed_y[23]}}, w.speed_y};
    px28 = {{4{w.pos_x[23]}}, w.pos_x};
    sx28 = {{4{w.speed_x[23]}}, w.speed_x};
    r28 = $signed({9'd0, w.radius, 8'd0});
    fl28 = $signed({8'd0, arena_height, 8'd0});
    wl28 = $signed({8'd0, arena_width, 8'd0});
    nx28 = px28 + sx28;
    fall = (py28 + r28 + sy28) < fl28;
    hit = ((nx28 + r28) > wl28) || ((nx28 - r28) < 28'sd0);
    gnd_now = ($signed({{4{mem_rdata.pos_y[23]}}, mem_rdata.pos_y})
               + $signed({9'd0, mem_rdata.radius, 8'd0})) >= fl28;
    al = {{3{w.box_cx[23]}}, w.box_cx} - $signed({8'd0, w.half_w, 8'd0});
    ar = {{3{w.box_cx[23]}}, w.box_cx} + $signed({8'd0, w.half_w, 8'd0});
    at = {{3{w.box_cy[23]}}, w.box_cy} - $signed({8'd0, w.half_h, 8'd0});
    ab = {{3{w.box_cy[23]}}, w.box_cy} + $signed({8'd0, w.half_h, 8'd0});
    bl = {{3{mem_rdata.box_cx[23]}}, mem_rdata.box_cx}
         - $signed({8'd0, mem_rdata.half_w, 8'd0});
    br = {{3{mem_rdata.box_cx[23]}}, mem_rdata.box_cx}
         + $signed({8'd0, mem_rdata.half_w, 8'd0});
    bt = {{3{mem_rdata.box_cy[23]}}, mem_rdata.box_cy}
         - $signed({8'd0, mem_rdata.half_h, 8'd0});
    bb = {{3{mem_rdata.box_cy[23]}}, mem_rdata.box_cy}
         + $signed({8'd0, mem_rdata.half_h, 8'd0});
    ovl = (al < br) && (ar > bl) && (at < bb) && (ab > bt);
  end

  always_comb begin
    size_sum = {1'b0, box_width} + {1'b0, box_height};
    load_word.pos_x = start_x;
    load_word.pos_y = start_y;
    load_word.speed_x = horiz_speed;
    load_word.speed_y = 24'sd0;
    load_word.drift_y = vert_drift;
    load_word.box_cx = start_x;
    load_word.box_cy = start_y;
    load_word.half_w = box_width[11:1];
    load_word.half_h = box_height[11:1];
    load_word.radius = size_sum[12:2];
    load_word.mode = mode_flags;
    load_word.weight = mass_weight;
    load_word.bounce = bounce_factor;
    load_word.drag = drag_factor;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = {w.speed_y[23], w.speed_y};
    mul_b = -$signed({4'd0, w.bounce});
    unique case (state)
      S_GRAV: begin
        if (fall) begin
          mul_a = $signed({13'd0, gravity_accel});
          mul_b = $signed({1'b0, w.weight});
        end
      end
      S_PAIR_O: begin
        mul_a = {o_sy[23], o_sy};
        mul_b = -$signed({4'd0, ow.bounce});
      end
      S_WALL: begin
        mul_a = {w.speed_x[23], w.speed_x};
      end
      S_FRIC: begin
        mul_a = {w.speed_x[23], w.speed_x};
        mul_b = 13'sd256 - $signed({4'd0, w.drag});
      end
      default: begin
      end
    endcase
  end

  // table read address and write select
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = i;
    mem_wdata = w;
    mem_raddr = (state == S_SCAN) ? i : j;
    unique case (state)
      S_IDLE: begin
        mem_we = start && (operation == bgb_pkg::OP_LOAD) && load_ok;
        mem_waddr = IW'(body_index);
        mem_wdata = load_word;
      end
      S_PAIR_WR: begin
        mem_we = 1'b1;
        mem_waddr = j;
        mem_wdata = ow;
        mem_wdata.speed_y = o_sy;
      end
      S_EMIT: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      result_strobe <= 1'b0;
      i <= '0;
      j <= '0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (operation == bgb_pkg::OP_LOAD) begin
              if (load_ok) begin
                slot_valid[IW'(body_index)] <= 1'b1;
              end
            end else begin
              i <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (slot_valid[i]) begin
            state <= S_LOADB;
          end else if (i == LAST) begin
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_LOADB: begin
          w <= mem_rdata;
          w.box_cx <= mem_rdata.pos_x;
          w.box_cy <= mem_rdata.pos_y;
          grounded <= gnd_now;
          state <= S_GRAV;
        end
        S_GRAV: begin
          j <= '0;
          state <= w.mode[bgb_pkg::FLAG_GRAVITY] ? S_GRAV_M : S_PAIR_ADDR;
        end
        S_GRAV_M: begin
          if (fall) begin
            w.speed_y <= w.speed_y + scaled;
          end else if (w.mode[bgb_pkg::FLAG_ELASTIC]) begin
            w.speed_y <= scaled;
          end else begin
            w.speed_y <= 24'sd0;
            w.pos_y <= 24'(fl28 - r28);
          end
          state <= S_GRAV_P;
        end
        S_GRAV_P: begin
          w.pos_y <= w.pos_y + w.speed_y;
          state <= S_PAIR_ADDR;
        end
        S_PAIR_ADDR: begin
          if (j != i && slot_valid[j]) begin
            state <= S_PAIR_CHK;
          end else if (j == LAST) begin
            state <= S_WALL;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_PAIR_CHK: begin
          ow <= mem_rdata;
          if (!ovl) begin
            o_sy <= mem_rdata.speed_y;
            if (j == LAST) begin
              state <= S_WALL;
            end else begin
              j <= j + 1'b1;
              state <= S_PAIR_ADDR;
            end
          end else if (w.mode[bgb_pkg::FLAG_ELASTIC]) begin
            o_sy <= mem_rdata.speed_y;
            state <= S_PAIR_B;
          end else begin
            w.speed_y <= 24'sd0;
            o_sy <= 24'sd0;
            state <= S_PAIR_O;
          end
        end
        S_PAIR_B: begin
          w.speed_y <= scaled;
          state <= S_PAIR_O;
        end
        S_PAIR_O: begin
          if (ow.mode[bgb_pkg::FLAG_ELASTIC]) begin
            state <= S_PAIR_OM;
          end else begin
            w.speed_y <= 24'sd0;
            o_sy <= 24'sd0;
            state <= S_PAIR_WR;
          end
        end
        S_PAIR_OM: begin
          o_sy <= scaled;
          state <= S_PAIR_WR;
        end
        S_PAIR_WR: begin
          if (j == LAST) begin
            state <= S_WALL;
          end else begin
            j <= j + 1'b1;
            state <= S_PAIR_ADDR;
          end
        end
        S_WALL: begin
          if (w.speed_x == 24'sd0) begin
            state <= S_DRIFT;
          end else if (hit && w.mode[bgb_pkg::FLAG_ELASTIC]
                       && w.mode[bgb_pkg::FLAG_FRICTION]) begin
            state <= S_WALL_M;
          end else begin
            if (hit) begin
              w.speed_x <= w.mode[bgb_pkg::FLAG_ELASTIC] ? -w.speed_x : 24'sd0;
            end
            state <= S_FRIC;
          end
        end
        S_WALL_M: begin
          w.speed_x <= scaled;
          state <= S_FRIC;
        end
        S_FRIC: begin
          state <= (w.mode[bgb_pkg::FLAG_FRICTION] && grounded) ? S_FRIC_M : S_MOVEX;
        end
        S_FRIC_M: begin
          w.speed_x <= scaled;
          state <= S_MOVEX;
        end
        S_MOVEX: begin
          w.pos_x <= w.pos_x + w.speed_x;
          state <= S_DRIFT;
        end
        S_DRIFT: begin
          w.pos_y <= w.pos_y + w.drift_y;
          state <= S_EMIT;
        end
        S_EMIT: begin
          result_strobe <= 1'b1;
          out_index <= 3'(i);
          out_x <= w.pos_x;
          out_y <= w.pos_y;
          on_ground <= grounded;
          last_body <= (((slot_valid >> i) >> 1) == '0);
          if (i == LAST) begin
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
            state <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/bgb_checker.sv
// port level checks for the gravity bounce step unit
module bgb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic result_strobe
);

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_strobe) else $error("result right after reset");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy)) else $error("result without a tick in flight");

  a_results_spaced: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe) else $error("back to back results");

  a_tick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == bgb_pkg::OP_TICK) |=> busy)
    else $error("tick request did not start");

endmodule

bind body_gravity_bounce_step_unit bgb_checker u_bgb_checker (.*);
